FILE: rtl/swmr_pkg.sv
// swmr_pkg: shared types and codes for the stack with middle reverse
// no dependencies; used by the interfaces and by stack_with_middle_reverse

package swmr_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 9;

  typedef enum logic [1:0] {
    CmdPush    = 2'd0,
    CmdPop     = 2'd1,
    CmdPeek    = 2'd2,
    CmdReverse = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SRdHi,
    SWrHi,
    SWrLo
  } state_e;

endpackage

FILE: rtl/swmr_if.sv
// swmr_req_if and swmr_res_if: valid/ready channels of the stack block
// depends on swmr_pkg

interface swmr_req_if;
  logic                             valid;
  logic                             ready;
  swmr_pkg::cmd_e                   command;
  logic signed [swmr_pkg::WordW-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface swmr_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [swmr_pkg::WordW-1:0]  value_res;
  swmr_pkg::status_e                 status;
  logic [swmr_pkg::CountW-1:0]       count;

  modport source (output valid, output value_res, output status, output count,
                  input ready);
  modport sink   (input valid, input value_res, input status, input count,
                  output ready);
endinterface

FILE: rtl/swmr_ram.sv
// swmr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module swmr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/stack_with_middle_reverse.sv
// stack_with_middle_reverse: lifo stack of 32-bit words with a middle-half reverse
// depends on swmr_pkg, swmr_if (swmr_req_if, swmr_res_if) and swmr_ram

// The stack words live in one ram with a single write port and a registered
// read port; the fill count sits in a flip-flop register. A push, a refused
// push, a pop or peek on an empty stack and a reverse that moves nothing are
// answered straight from the idle state. A pop or peek that hits the store goes
// through SRead to wait for the registered ram read. A reverse walks the range
// from count/4 to count-count/4-1 from both ends and swaps one pair of words per
// pass through SRdHi, SWrHi and SWrLo (read low, read high, write high, write
// low with the next low read overlapped).
// The block takes a new command once the previous one is finished and the
// result register is free or being emptied in the same cycle. No clearing
// pass is needed after reset: only entries below the count are ever read.

module stack_with_middle_reverse #(
  parameter int unsigned DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swmr_req_if.sink   req_i,
  swmr_res_if.source res_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned ExtW  = (CntW > swmr_pkg::CountW) ? CntW : swmr_pkg::CountW;

  swmr_pkg::state_e state_q, state_d;

  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [AddrW-1:0]           lo_q, lo_d, hi_q, hi_d;
  logic [swmr_pkg::WordW-1:0] tmp_q, tmp_d;

  logic                       out_valid_q, out_valid_d;
  logic [swmr_pkg::WordW-1:0] out_value_q, out_value_d;
  swmr_pkg::status_e          out_status_q, out_status_d;
  logic [swmr_pkg::CountW-1:0] out_count_q, out_count_d;

  logic                       ram_we;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [swmr_pkg::WordW-1:0] ram_wdata, ram_rdata;

  logic                       accept;
  logic                       full, empty;
  logic [CntW-1:0]            quarter, rev_hi;
  logic [AddrW-1:0]           lo_next, hi_next;
  logic [ExtW-1:0]            cnt_ext;

  swmr_ram #(
    .Width (swmr_pkg::WordW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == swmr_pkg::SIdle) && (!out_valid_q || res_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign full    = (cnt_q == CntW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign quarter = cnt_q >> 2;
  assign rev_hi  = cnt_q - quarter - CntW'(1);
  assign lo_next = lo_q + AddrW'(1);
  assign hi_next = hi_q - AddrW'(1);
  assign cnt_ext = ExtW'(cnt_d);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    tmp_d        = tmp_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    case (state_q)
      swmr_pkg::SIdle: begin
        if (accept) begin
          case (req_i.command)
            swmr_pkg::CmdPush: begin
              out_valid_d  = 1'b1;
              out_value_d  = '0;
              if (full) begin
                out_status_d = swmr_pkg::StFull;
              end else begin
                out_status_d = swmr_pkg::StOk;
                ram_we       = 1'b1;
                ram_waddr    = cnt_q[AddrW-1:0];
                ram_wdata    = req_i.value;
                cnt_d        = cnt_q + CntW'(1);
              end
            end
            swmr_pkg::CmdPop,
            swmr_pkg::CmdPeek: begin
              if (empty) begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_status_d = swmr_pkg::StEmpty;
              end else begin
                ram_raddr = AddrW'(cnt_q - CntW'(1));
                state_d   = swmr_pkg::SRead;
                if (req_i.command == swmr_pkg::CmdPop) begin
                  cnt_d = cnt_q - CntW'(1);
                end
              end
            end
            default: begin
              // reverse: start the swap walk only if the range holds two or more words
              if ((cnt_q >= CntW'(2)) && (quarter < rev_hi)) begin
                lo_d      = AddrW'(quarter);
                hi_d      = AddrW'(rev_hi);
                ram_raddr = AddrW'(quarter);
                state_d   = swmr_pkg::SRdHi;
              end else begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_status_d = swmr_pkg::StOk;
              end
            end
          endcase
        end
      end

      swmr_pkg::SRead: begin
        out_valid_d  = 1'b1;
        out_value_d  = ram_rdata;
        out_status_d = swmr_pkg::StOk;
        state_d      = swmr_pkg::SIdle;
      end

      swmr_pkg::SRdHi: begin
        // low word arrives, fetch the high one
        tmp_d     = ram_rdata;
        ram_raddr = hi_q;
        state_d   = swmr_pkg::SWrHi;
      end

      swmr_pkg::SWrHi: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = tmp_q;
        tmp_d     = ram_rdata;
        state_d   = swmr_pkg::SWrLo;
      end

      swmr_pkg::SWrLo: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = tmp_q;
        lo_d      = lo_next;
        hi_d      = hi_next;
        if (lo_next < hi_next) begin
          // next low read overlaps this write
          ram_raddr = lo_next;
          state_d   = swmr_pkg::SRdHi;
        end else begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_status_d = swmr_pkg::StOk;
          state_d      = swmr_pkg::SIdle;
        end
      end

      default: begin
        state_d = swmr_pkg::SIdle;
      end
    endcase
  end

  assign out_count_d = cnt_ext[swmr_pkg::CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swmr_pkg::SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    tmp_q <= tmp_d;
    if (out_valid_d && !(out_valid_q && !res_o.ready)) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.value_res = out_value_q;
  assign res_o.status    = out_status_q;
  assign res_o.count     = out_count_q;

endmodule

FILE: tb/sv/stack_with_middle_reverse_tb.sv
// stack_with_middle_reverse_tb: self-checking bench for the lifo stack with middle reverse
// depends on swmr_pkg, swmr_if (swmr_req_if, swmr_res_if) and the stack_with_middle_reverse rtl
// commands go through a gap-inserting driver; a stalling monitor checks results in order

module stack_with_middle_reverse_tb;

  localparam int          ClkPeriod   = 8;
  localparam int unsigned StackDepth  = 256;
  localparam int unsigned RandItems   = 850;
  localparam int unsigned LimitCycles = 1_000_000;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    swmr_pkg::cmd_e                    cmd;
    logic signed [swmr_pkg::WordW-1:0] word;
  } stack_cmd_t;

  typedef struct packed {
    logic signed [swmr_pkg::WordW-1:0] value_res;
    swmr_pkg::status_e                 status;
    logic [swmr_pkg::CountW-1:0]       count;
  } stack_res_t;

  logic clk_i;
  logic rst_ni;

  swmr_req_if req_if ();
  swmr_res_if res_if ();

  stack_with_middle_reverse #(
    .DEPTH(StackDepth)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // shadow copy of the stack contents
  logic signed [swmr_pkg::WordW-1:0] shadow_mem [StackDepth];
  int unsigned                       shadow_fill;

  stack_cmd_t  cmd_q [$];
  stack_res_t  pending_res_q [$];

  int unsigned gen_fill;
  int unsigned n_queued;
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_refused;
  int unsigned n_empty_reads;
  int unsigned n_flips;
  int unsigned peak_fill;
  int unsigned req_idle, req_calm;
  int unsigned res_stall, res_calm;

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [swmr_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_cmd(swmr_pkg::cmd_e c,
                                    logic signed [swmr_pkg::WordW-1:0] w);
    cmd_q.push_back('{cmd: c, word: w});
    n_queued++;
    case (c)
      swmr_pkg::CmdPush: if (gen_fill < StackDepth) gen_fill++;
      swmr_pkg::CmdPop:  if (gen_fill > 0) gen_fill--;
      default: ;
    endcase
  endfunction

  // applies one accepted command to the shadow stack and returns its result
  function automatic stack_res_t apply_stack_cmd(stack_cmd_t c);
    stack_res_t                        r;
    int                                lo;
    int                                hi;
    logic signed [swmr_pkg::WordW-1:0] tmp;
    r.value_res = '0;
    r.status    = swmr_pkg::StOk;
    case (c.cmd)
      swmr_pkg::CmdPush: begin
        if (shadow_fill >= StackDepth) begin
          r.status = swmr_pkg::StFull;
          n_refused++;
        end else begin
          shadow_mem[shadow_fill] = c.word;
          shadow_fill++;
        end
      end
      swmr_pkg::CmdPop: begin
        if (shadow_fill == 0) begin
          r.status = swmr_pkg::StEmpty;
          n_empty_reads++;
        end else begin
          shadow_fill--;
          r.value_res = shadow_mem[shadow_fill];
        end
      end
      swmr_pkg::CmdPeek: begin
        if (shadow_fill == 0) begin
          r.status = swmr_pkg::StEmpty;
          n_empty_reads++;
        end else begin
          r.value_res = shadow_mem[shadow_fill - 1];
        end
      end
      default: begin
        lo = int'(shadow_fill / 4);
        hi = int'(shadow_fill) - lo - 1;
        if (lo < hi) n_flips++;
        while (lo < hi) begin
          tmp            = shadow_mem[lo];
          shadow_mem[lo] = shadow_mem[hi];
          shadow_mem[hi] = tmp;
          lo++;
          hi--;
        end
      end
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.count = shadow_fill[swmr_pkg::CountW-1:0];
    return r;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    stack_cmd_t nb;
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.command <= swmr_pkg::CmdPush;
      req_if.value   <= '0;
      req_idle       <= 0;
    end else begin
      if (req_if.valid && req_if.ready)
        pending_res_q.push_back(apply_stack_cmd('{cmd: req_if.command, word: req_if.value}));
      if (!req_if.valid || req_if.ready) begin
        if (req_idle > 0) begin
          req_idle     <= req_idle - 1;
          req_if.valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          nb = cmd_q.pop_front();
          req_if.valid   <= 1'b1;
          req_if.command <= nb.cmd;
          req_if.value   <= nb.word;
          req_idle       <= pick_gap(req_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    stack_res_t  want;
    int unsigned g;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_stall    <= 0;
    end else if (res_if.valid && res_if.ready) begin
      n_results++;
      if (pending_res_q.size() == 0) begin
        $error("result beat with nothing expected: value_res %0d status %0d count %0d",
               res_if.value_res, res_if.status, res_if.count);
        n_errors++;
      end else begin
        want = pending_res_q.pop_front();
        if (res_if.value_res !== want.value_res) begin
          $error("value_res: expected %0d, got %0d", want.value_res, res_if.value_res);
          n_errors++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          n_errors++;
        end
        if (res_if.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, res_if.count);
          n_errors++;
        end
      end
      g = pick_gap(res_calm);
      res_stall    <= g;
      res_if.ready <= (g == 0);
    end else if (res_stall > 0) begin
      res_stall    <= res_stall - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  initial begin : stim_p
    int unsigned kind;
    int unsigned len;
    bit          full_done;
    bit          empty_done;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.command = swmr_pkg::CmdPush;
    req_if.value   = '0;
    res_if.ready   = 1'b0;
    shadow_fill    = 0;
    gen_fill       = 0;
    full_done      = 1'b0;
    empty_done     = 1'b0;

    // directed: empty reads, extreme words, reverses over the smallest ranges
    queue_cmd(swmr_pkg::CmdPeek, $urandom);
    queue_cmd(swmr_pkg::CmdPop, $urandom);
    queue_cmd(swmr_pkg::CmdReverse, $urandom);
    queue_cmd(swmr_pkg::CmdPush, 32'sh7fff_ffff);
    queue_cmd(swmr_pkg::CmdReverse, $urandom);
    queue_cmd(swmr_pkg::CmdPush, 32'sh8000_0000);
    queue_cmd(swmr_pkg::CmdReverse, $urandom);
    queue_cmd(swmr_pkg::CmdPeek, $urandom);
    queue_cmd(swmr_pkg::CmdPush, '0);
    queue_cmd(swmr_pkg::CmdPush, '1);
    queue_cmd(swmr_pkg::CmdPush, 32'sh5555_5555);
    queue_cmd(swmr_pkg::CmdPush, 32'shaaaa_aaaa);
    queue_cmd(swmr_pkg::CmdReverse, $urandom);
    queue_cmd(swmr_pkg::CmdPop, $urandom);
    queue_cmd(swmr_pkg::CmdReverse, $urandom);
    queue_cmd(swmr_pkg::CmdPop, $urandom);
    queue_cmd(swmr_pkg::CmdPeek, $urandom);
    queue_cmd(swmr_pkg::CmdPop, $urandom);
    queue_cmd(swmr_pkg::CmdPop, $urandom);
    queue_cmd(swmr_pkg::CmdPop, $urandom);
    queue_cmd(swmr_pkg::CmdPop, $urandom);
    queue_cmd(swmr_pkg::CmdPop, $urandom);
    queue_cmd(swmr_pkg::CmdPeek, $urandom);

    // random episodes; one fill past full and one drain past empty are forced
    while (n_queued < RandItems + 23) begin
      kind = $urandom_range(0, 99);
      if (!full_done && n_queued >= 250) kind = 0;
      else if (full_done && !empty_done && n_queued >= 600) kind = 10;
      if (kind < 6) begin
        while (gen_fill < StackDepth) begin
          case ($urandom_range(0, 19))
            0:       queue_cmd(swmr_pkg::CmdReverse, $urandom);
            1:       queue_cmd(swmr_pkg::CmdPeek, $urandom);
            default: queue_cmd(swmr_pkg::CmdPush, pick_word());
          endcase
        end
        len = $urandom_range(2, 4);
        repeat (len) queue_cmd(swmr_pkg::CmdPush, pick_word());
        queue_cmd(swmr_pkg::CmdReverse, $urandom);
        queue_cmd(swmr_pkg::CmdPeek, $urandom);
        full_done = 1'b1;
      end else if (kind < 12) begin
        while (gen_fill > 0) begin
          case ($urandom_range(0, 19))
            0:       queue_cmd(swmr_pkg::CmdReverse, $urandom);
            1:       queue_cmd(swmr_pkg::CmdPeek, $urandom);
            default: queue_cmd(swmr_pkg::CmdPop, $urandom);
          endcase
        end
        len = $urandom_range(1, 3);
        repeat (len)
          queue_cmd($urandom_range(0, 1) ? swmr_pkg::CmdPop : swmr_pkg::CmdPeek,
                    $urandom);
        empty_done = 1'b1;
      end else begin
        len = $urandom_range(20, 60);
        repeat (len) begin
          kind = $urandom_range(0, 99);
          if (kind < 40)      queue_cmd(swmr_pkg::CmdPush, pick_word());
          else if (kind < 65) queue_cmd(swmr_pkg::CmdPop, $urandom);
          else if (kind < 80) queue_cmd(swmr_pkg::CmdPeek, $urandom);
          else                queue_cmd(swmr_pkg::CmdReverse, $urandom);
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() > 0 || req_if.valid) @(posedge clk_i);
    while (pending_res_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d commands, %0d result beats; peak depth %0d of %0d",
             n_queued, n_results, peak_fill, StackDepth);
    $display("refused pushes %0d, empty reads %0d, reverses that moved words %0d",
             n_refused, n_empty_reads, n_flips);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog_p
    #(longint'(LimitCycles) * ClkPeriod);
    $display("timeout with %0d commands and %0d results outstanding",
             cmd_q.size(), pending_res_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: stack_with_middle_reverse.f
rtl/swmr_pkg.sv
rtl/swmr_if.sv
rtl/swmr_ram.sv
rtl/stack_with_middle_reverse.sv
tb/sv/stack_with_middle_reverse_tb.sv
